// ===== src/cau_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Shared widths, codes and word types of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 28;
  localparam int PROD_BITS  = 2 * WORD_BITS;
  localparam int SUM_BITS   = PROD_BITS + 2;
  localparam int ITER_STEPS = WORD_BITS;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_SQR = 3'd4,
    OP_MAG = 3'd5
  } opcode_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic [2:0]                  opcode;
    logic signed [WORD_BITS-1:0] a_re;
    logic signed [WORD_BITS-1:0] a_im;
    logic signed [WORD_BITS-1:0] b_re;
    logic signed [WORD_BITS-1:0] b_im;
  } in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] res_re;
    logic signed [WORD_BITS-1:0] res_im;
    logic [1:0]                  status;
  } out_t;

  // One word in flight through the shared divide / square-root stages.
  typedef struct packed {
    logic                 is_div;
    logic                 is_sqrt;
    logic                 ovf_re;
    logic                 ovf_im;
    logic                 neg_re;
    logic                 neg_im;
    logic [PROD_BITS-1:0] dvs;     // divisor, or radicand for square root
    logic [PROD_BITS-1:0] rem_re;
    logic [PROD_BITS-1:0] rem_im;
    logic [WORD_BITS-1:0] lo_re;   // dividend bits still to bring down
    logic [WORD_BITS-1:0] lo_im;
    logic [WORD_BITS-1:0] q_re;    // quotient, or root
    logic [WORD_BITS-1:0] q_im;
    logic [WORD_BITS-1:0] res_re;  // finished result of the simple ops
    logic [WORD_BITS-1:0] res_im;
    logic [1:0]           status;
  } iter_t;

endpackage

// ===== src/complex_arithmetic_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Fixed-point complex ALU: add, subtract, multiply, divide, square, magnitude.
// ----------------------------------------------------------------------------
//  channel  ports                     handshake
//  input    start, busy, in_data      word taken when start && !busy
//  result   out_valid, out_data       one-cycle strobe, cannot be held off
//
//  A word enters every cycle; busy is never raised.
//  Stages in order: input register, product stage, sum stage, set-up
//  stage, one stage per quotient / root bit, output.
//  The bit-per-stage divide and square-root pipe sets the depth.
//  Synchronous active-low reset clears the valid bits only; data is dropped.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit import cau_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  localparam int SHIFT_BITS = WORD_BITS - FRAC_BITS;
  localparam logic [WORD_BITS-1:0] WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 ovf;
  } sat_t;

  // clamp a wide signed value into one word
  function automatic sat_t sat_wide(input logic signed [SUM_BITS-1:0] v);
    sat_t r;
    begin
      if (&v[SUM_BITS-1:WORD_BITS-1] || ~|v[SUM_BITS-1:WORD_BITS-1]) begin
        r.val = v[WORD_BITS-1:0];
        r.ovf = 1'b0;
      end else begin
        r.val = v[SUM_BITS-1] ? WORD_MIN : WORD_MAX;
        r.ovf = 1'b1;
      end
      return r;
    end
  endfunction

  // apply sign to an unsigned magnitude and clamp
  function automatic sat_t sat_mag(input logic [WORD_BITS-1:0] q, input logic neg);
    sat_t r;
    begin
      r.ovf = 1'b0;
      if (neg) begin
        if (q[WORD_BITS-1] && |q[WORD_BITS-2:0]) begin
          r.val = WORD_MIN;
          r.ovf = 1'b1;
        end else begin
          r.val = -q;
        end
      end else if (q[WORD_BITS-1]) begin
        r.val = WORD_MAX;
        r.ovf = 1'b1;
      end else begin
        r.val = q;
      end
      return r;
    end
  endfunction

  assign busy = 1'b0;

  // --- input register -------------------------------------------------------
  logic in_vld_r;
  in_t  in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    in_r <= in_data;
  end

  // --- stage 1: products, and add / subtract finished -----------------------
  // m0 ar*br, m1 ai*bi, m2 ar*bi (ar*ai for square), m3 ai*br,
  // m4/m5 squares of b for divide, of a otherwise
  logic signed [WORD_BITS-1:0] m2_b, sq_x, sq_y;
  logic signed [SUM_BITS-1:0]  lin_re, lin_im;

  always_comb begin
    m2_b = (in_r.opcode == OP_SQR) ? in_r.a_im : in_r.b_im;
    sq_x = (in_r.opcode == OP_DIV) ? in_r.b_re : in_r.a_re;
    sq_y = (in_r.opcode == OP_DIV) ? in_r.b_im : in_r.a_im;
    if (in_r.opcode == OP_SUB) begin
      lin_re = SUM_BITS'(in_r.a_re) - SUM_BITS'(in_r.b_re);
      lin_im = SUM_BITS'(in_r.a_im) - SUM_BITS'(in_r.b_im);
    end else begin
      lin_re = SUM_BITS'(in_r.a_re) + SUM_BITS'(in_r.b_re);
      lin_im = SUM_BITS'(in_r.a_im) + SUM_BITS'(in_r.b_im);
    end
  end

  logic                        s1_vld_r;
  logic [2:0]                  s1_op_r;
  logic signed [PROD_BITS-1:0] m0_r, m1_r, m2_r, m3_r, m4_r, m5_r;
  sat_t                        s1_lre_r, s1_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= in_r.opcode;
    m0_r     <= in_r.a_re * in_r.b_re;
    m1_r     <= in_r.a_im * in_r.b_im;
    m2_r     <= in_r.a_re * m2_b;
    m3_r     <= in_r.a_im * in_r.b_re;
    m4_r     <= sq_x * sq_x;
    m5_r     <= sq_y * sq_y;
    s1_lre_r <= sat_wide(lin_re);
    s1_lim_r <= sat_wide(lin_im);
  end

  // --- stage 2: exact sums of products --------------------------------------
  logic signed [SUM_BITS-1:0] sum_re, sum_im;

  always_comb begin
    case (s1_op_r)
      OP_MUL: begin
        sum_re = SUM_BITS'(m0_r) - SUM_BITS'(m1_r);
        sum_im = SUM_BITS'(m2_r) + SUM_BITS'(m3_r);
      end
      OP_SQR: begin
        sum_re = SUM_BITS'(m4_r) - SUM_BITS'(m5_r);
        sum_im = SUM_BITS'(m2_r) <<< 1;
      end
      OP_DIV: begin
        sum_re = SUM_BITS'(m0_r) + SUM_BITS'(m1_r);
        sum_im = SUM_BITS'(m3_r) - SUM_BITS'(m2_r);
      end
      default: begin
        sum_re = '0;
        sum_im = '0;
      end
    endcase
  end

  logic                       s2_vld_r;
  logic [2:0]                 s2_op_r;
  logic signed [SUM_BITS-1:0] s2_re_r, s2_im_r;
  logic [PROD_BITS-1:0]       s2_dsum_r;   // |b|^2 for divide, |a|^2 for magnitude
  sat_t                       s2_lre_r, s2_lim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_op_r   <= s1_op_r;
    s2_re_r   <= sum_re;
    s2_im_r   <= sum_im;
    s2_dsum_r <= $unsigned(m4_r) + $unsigned(m5_r);
    s2_lre_r  <= s1_lre_r;
    s2_lim_r  <= s1_lim_r;
  end

  // --- stage 3: scale products, set up divide / root ------------------------
  logic signed [SUM_BITS-1:0] shr_re, shr_im, abs_re, abs_im;
  logic [PROD_BITS-1:0]       num_re, num_im;
  sat_t                       fl_re, fl_im;
  iter_t                      setup;

  always_comb begin
    shr_re = s2_re_r >>> FRAC_BITS;
    shr_im = s2_im_r >>> FRAC_BITS;
    fl_re  = sat_wide(shr_re);
    fl_im  = sat_wide(shr_im);
    abs_re = s2_re_r[SUM_BITS-1] ? -s2_re_r : s2_re_r;
    abs_im = s2_im_r[SUM_BITS-1] ? -s2_im_r : s2_im_r;
    num_re = abs_re[PROD_BITS-1:0];
    num_im = abs_im[PROD_BITS-1:0];

    setup = '0;
    case (s2_op_r)
      OP_ADD, OP_SUB: begin
        setup.res_re = s2_lre_r.val;
        setup.res_im = s2_lim_r.val;
        setup.status = (s2_lre_r.ovf || s2_lim_r.ovf) ? ST_OVF : ST_OK;
      end
      OP_MUL, OP_SQR: begin
        setup.res_re = fl_re.val;
        setup.res_im = fl_im.val;
        setup.status = (fl_re.ovf || fl_im.ovf) ? ST_OVF : ST_OK;
      end
      OP_DIV: begin
        if (s2_dsum_r == '0) begin
          setup.status = ST_DZ;
        end else begin
          // dividend is |n| << FRAC_BITS; its top part seeds the remainder
          setup.is_div = 1'b1;
          setup.dvs    = s2_dsum_r;
          setup.neg_re = s2_re_r[SUM_BITS-1];
          setup.neg_im = s2_im_r[SUM_BITS-1];
          setup.rem_re = num_re >> SHIFT_BITS;
          setup.rem_im = num_im >> SHIFT_BITS;
          setup.lo_re  = {num_re[SHIFT_BITS-1:0], {FRAC_BITS{1'b0}}};
          setup.lo_im  = {num_im[SHIFT_BITS-1:0], {FRAC_BITS{1'b0}}};
          // quotient needs more than a word
          setup.ovf_re = (num_re >> SHIFT_BITS) >= s2_dsum_r;
          setup.ovf_im = (num_im >> SHIFT_BITS) >= s2_dsum_r;
        end
      end
      OP_MAG: begin
        setup.is_sqrt = 1'b1;
        setup.dvs     = s2_dsum_r;
      end
      default: begin
        setup.status = ST_OK;
      end
    endcase
  end

  logic  s3_vld_r;
  iter_t s3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_r <= setup;
  end

  // --- divide / square-root pipe --------------------------------------------
  logic  it_vld;
  iter_t it_out;

  cau_iter u_iter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_stage  (s3_r),
    .out_valid (it_vld),
    .out_stage (it_out)
  );

  // --- finish and output register -------------------------------------------
  sat_t q_re_s, q_im_s;
  out_t fin;

  always_comb begin
    q_re_s = sat_mag(it_out.q_re, it_out.neg_re && !it_out.is_sqrt);
    q_im_s = sat_mag(it_out.q_im, it_out.neg_im);
    if (it_out.ovf_re) begin
      q_re_s.val = it_out.neg_re ? WORD_MIN : WORD_MAX;
      q_re_s.ovf = 1'b1;
    end
    if (it_out.ovf_im) begin
      q_im_s.val = it_out.neg_im ? WORD_MIN : WORD_MAX;
      q_im_s.ovf = 1'b1;
    end

    if (it_out.is_sqrt) begin
      fin.res_re = q_re_s.val;
      fin.res_im = '0;
      fin.status = q_re_s.ovf ? ST_OVF : ST_OK;
    end else if (it_out.is_div) begin
      fin.res_re = q_re_s.val;
      fin.res_im = q_im_s.val;
      fin.status = (q_re_s.ovf || q_im_s.ovf) ? ST_OVF : ST_OK;
    end else begin
      fin.res_re = it_out.res_re;
      fin.res_im = it_out.res_im;
      fin.status = it_out.status;
    end
  end

  logic out_vld_r;
  out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= it_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= fin;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // --- assertions -----------------------------------------------------------
  localparam int LATENCY = ITER_STEPS + 5;

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted word");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_DZ) |->
      (out_data.res_re == '0 && out_data.res_im == '0))
    else $error("divide by zero result not cleared");

  a_ovf_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_OVF) |->
      (out_data.res_re == WORD_MAX || out_data.res_re == WORD_MIN ||
       out_data.res_im == WORD_MAX || out_data.res_im == WORD_MIN))
    else $error("overflow flagged without a clamped part");

endmodule

// ===== src/cau_iter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_iter
// Pipelined restoring divider and digit-by-digit square root, one quotient
// or root bit per stage.
// ----------------------------------------------------------------------------
module cau_iter import cau_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  iter_t in_stage,
  output logic  out_valid,
  output iter_t out_stage
);

  function automatic iter_t step(input iter_t s);
    iter_t                t;
    logic [PROD_BITS-1:0] r_re;
    logic [PROD_BITS-1:0] r_im;
    logic [PROD_BITS-1:0] trial;
    begin
      t     = s;
      r_im  = '0;
      if (s.is_sqrt) begin
        r_re  = {s.rem_re[PROD_BITS-3:0], s.dvs[PROD_BITS-1 -: 2]};
        trial = {{(PROD_BITS-WORD_BITS-2){1'b0}}, s.q_re, 2'b01};
        t.dvs = {s.dvs[PROD_BITS-3:0], 2'b00};
        if (r_re >= trial) begin
          t.rem_re = r_re - trial;
          t.q_re   = {s.q_re[WORD_BITS-2:0], 1'b1};
        end else begin
          t.rem_re = r_re;
          t.q_re   = {s.q_re[WORD_BITS-2:0], 1'b0};
        end
      end else begin
        r_re    = {s.rem_re[PROD_BITS-2:0], s.lo_re[WORD_BITS-1]};
        r_im    = {s.rem_im[PROD_BITS-2:0], s.lo_im[WORD_BITS-1]};
        t.lo_re = {s.lo_re[WORD_BITS-2:0], 1'b0};
        t.lo_im = {s.lo_im[WORD_BITS-2:0], 1'b0};
        if (r_re >= s.dvs) begin
          t.rem_re = r_re - s.dvs;
          t.q_re   = {s.q_re[WORD_BITS-2:0], 1'b1};
        end else begin
          t.rem_re = r_re;
          t.q_re   = {s.q_re[WORD_BITS-2:0], 1'b0};
        end
        if (r_im >= s.dvs) begin
          t.rem_im = r_im - s.dvs;
          t.q_im   = {s.q_im[WORD_BITS-2:0], 1'b1};
        end else begin
          t.rem_im = r_im;
          t.q_im   = {s.q_im[WORD_BITS-2:0], 1'b0};
        end
      end
      return t;
    end
  endfunction

  iter_t                 stg_r [ITER_STEPS];
  logic [ITER_STEPS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ITER_STEPS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= step(in_stage);
    for (int k = 1; k < ITER_STEPS; k++) begin
      stg_r[k] <= step(stg_r[k-1]);
    end
  end

  assign out_valid = vld_r[ITER_STEPS-1];
  assign out_stage = stg_r[ITER_STEPS-1];

endmodule
